>>> design/rwtd_pkg.sv
// rwtd_pkg: shared types and x86 byte codes for the rip-relative write target decoder
// no dependencies; imported by rwtd_parser, rwtd_target and the top level

package rwtd_pkg;

	localparam int ADDR_W = 64;
	localparam int DISP_W = 32;
	localparam int LEN_W  = 4;   // holds any instruction length up to 15
	localparam int SEEN_W = 3;

	// legacy prefixes
	localparam logic [7:0] PFX_LOCK   = 8'hF0;
	localparam logic [7:0] PFX_REPNE  = 8'hF2;
	localparam logic [7:0] PFX_REP    = 8'hF3;
	localparam logic [7:0] PFX_CS     = 8'h2E;
	localparam logic [7:0] PFX_SS     = 8'h36;
	localparam logic [7:0] PFX_DS     = 8'h3E;
	localparam logic [7:0] PFX_ES     = 8'h26;
	localparam logic [7:0] PFX_FS     = 8'h64;
	localparam logic [7:0] PFX_GS     = 8'h65;
	localparam logic [7:0] PFX_OPSIZE = 8'h66;
	localparam logic [7:0] PFX_ADSIZE = 8'h67;

	localparam logic [7:0] REX_MASK = 8'hF0;
	localparam logic [7:0] REX_BASE = 8'h40;

	// opcodes
	localparam logic [7:0] OP_ESCAPE     = 8'h0F;
	localparam logic [7:0] OP_XADD       = 8'hC1;
	localparam logic [7:0] OP_MOV_RM_R   = 8'h89;
	localparam logic [7:0] OP_ADD_RM_R   = 8'h01;
	localparam logic [7:0] OP_MOV_RM_IMM = 8'hC7;
	localparam logic [7:0] OP_GRP1_IMM32 = 8'h81;
	localparam logic [7:0] OP_GRP1_IMM8  = 8'h83;
	localparam logic [7:0] OP_GRP5       = 8'hFF;

	// modrm fields
	localparam logic [7:0] MODRM_MODRM_MASK = 8'hC7;
	localparam logic [7:0] MODRM_RIP_DISP32 = 8'h05;
	localparam logic [7:0] MODRM_REG_MASK   = 8'h38;

	typedef enum logic [2:0] {
		PH_PREFIX,
		PH_OPCODE,
		PH_ESCAPE,
		PH_MODRM,
		PH_DISP,
		PH_TAIL
	} phase_t;

	// finished instruction handed from the parser to the target stage
	typedef struct packed {
		logic              hit;
		logic [ADDR_W-1:0] start;
		logic [LEN_W-1:0]  len;
		logic [DISP_W-1:0] disp;
	} decode_t;

endpackage

>>> design/rwtd_if.sv
// rwtd_if: valid/ready channels for instruction bytes and decode reports
// no dependencies

interface rwtd_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  code_byte;
	logic [63:0] instruction_address;
	logic        last_byte;

	modport source (output valid, code_byte, instruction_address, last_byte, input ready);
	modport sink   (input valid, code_byte, instruction_address, last_byte, output ready);
endinterface

interface rwtd_out_if;
	logic        valid;
	logic        ready;
	logic        is_rip_write;
	logic [63:0] write_target;
	logic        hits_watched;

	modport source (output valid, is_rip_write, write_target, hits_watched, input ready);
	modport sink   (input valid, is_rip_write, write_target, hits_watched, output ready);
endinterface

>>> design/rwtd_parser.sv
// rwtd_parser: per-byte instruction parse state and the first pipeline stage
// depends on rwtd_pkg and rwtd_in_if

module rwtd_parser #(
	parameter int MAX_INSTR_BYTES = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	rwtd_in_if.sink           instr,
	input  logic              adv_s1,
	output logic              valid_s1,
	output rwtd_pkg::decode_t dec_s1
);
	import rwtd_pkg::*;

	phase_t              phase_q, phase_d;
	logic [LEN_W-1:0]    cnt_q, cnt_d;
	logic                any_reg_q, any_reg_d;
	logic [SEEN_W-1:0]   seen_q, seen_d;
	logic [DISP_W-1:0]   disp_q, disp_d;
	logic [ADDR_W-1:0]   start_q, start_d;
	logic                rej_q, rej_d;

	logic       take;
	logic       over_len;
	logic       blocked;
	logic       bad_byte;
	logic       is_prefix;
	logic       is_rex;
	logic       modrm_ok;
	logic       op_bad;
	logic       op_any;
	phase_t     op_phase;
	logic [7:0] b;

	assign b        = instr.code_byte;
	assign instr.ready = !valid_s1 || adv_s1;
	assign take     = instr.valid && instr.ready;

	assign over_len = cnt_q >= LEN_W'(MAX_INSTR_BYTES);
	assign blocked  = rej_q || over_len;
	assign cnt_d    = over_len ? cnt_q : cnt_q + LEN_W'(1);
	assign start_d  = (cnt_q == '0) ? instr.instruction_address : start_q;

	assign is_prefix = (b == PFX_LOCK) || (b == PFX_REPNE) || (b == PFX_REP) ||
		(b == PFX_CS) || (b == PFX_SS) || (b == PFX_DS) || (b == PFX_ES) ||
		(b == PFX_FS) || (b == PFX_GS) || (b == PFX_OPSIZE) || (b == PFX_ADSIZE);
	assign is_rex   = (b & REX_MASK) == REX_BASE;
	assign modrm_ok = ((b & MODRM_MODRM_MASK) == MODRM_RIP_DISP32) &&
		(any_reg_q || ((b & MODRM_REG_MASK) == 8'h00));

	// opcode decode, shared by the prefix and opcode phases
	always_comb begin
		op_phase = PH_MODRM;
		op_any   = any_reg_q;
		op_bad   = 1'b0;
		unique case (b)
			OP_ESCAPE: begin
				op_phase = PH_ESCAPE;
			end
			OP_MOV_RM_R, OP_ADD_RM_R: begin
				op_any = 1'b1;
			end
			OP_MOV_RM_IMM, OP_GRP1_IMM32, OP_GRP1_IMM8, OP_GRP5: begin
				op_any = 1'b0;
			end
			default: begin
				op_phase = phase_q;
				op_bad   = 1'b1;
			end
		endcase
	end

	// next phase
	always_comb begin
		phase_d   = phase_q;
		any_reg_d = any_reg_q;
		bad_byte  = 1'b0;
		if (!blocked) begin
			unique case (phase_q)
				PH_PREFIX: begin
					if (!is_prefix) begin
						if (is_rex) begin
							phase_d = PH_OPCODE;
						end else begin
							phase_d   = op_phase;
							any_reg_d = op_any;
							bad_byte  = op_bad;
						end
					end
				end
				PH_OPCODE: begin
					phase_d   = op_phase;
					any_reg_d = op_any;
					bad_byte  = op_bad;
				end
				PH_ESCAPE: begin
					if (b == OP_XADD) begin
						any_reg_d = 1'b1;
						phase_d   = PH_MODRM;
					end else begin
						bad_byte = 1'b1;
					end
				end
				PH_MODRM: begin
					if (modrm_ok) begin
						phase_d = PH_DISP;
					end else begin
						bad_byte = 1'b1;
					end
				end
				PH_DISP: begin
					if (seen_q == SEEN_W'(3)) begin
						phase_d = PH_TAIL;
					end
				end
				PH_TAIL: begin
					phase_d = PH_TAIL;
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	// displacement gathering and reject flag
	always_comb begin
		seen_d = seen_q;
		disp_d = disp_q;
		rej_d  = blocked || bad_byte;
		if (!blocked && phase_q == PH_MODRM && modrm_ok) begin
			seen_d = '0;
			disp_d = '0;
		end else if (!blocked && phase_q == PH_DISP) begin
			// little-endian: byte lands at lane seen
			disp_d = disp_q | (DISP_W'(b) << {seen_q[1:0], 3'b000});
			seen_d = seen_q + SEEN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_PREFIX;
			cnt_q     <= '0;
			any_reg_q <= 1'b0;
			seen_q    <= '0;
			disp_q    <= '0;
			start_q   <= '0;
			rej_q     <= 1'b0;
		end else if (take) begin
			if (instr.last_byte) begin
				phase_q   <= PH_PREFIX;
				cnt_q     <= '0;
				any_reg_q <= 1'b0;
				seen_q    <= '0;
				disp_q    <= '0;
				start_q   <= '0;
				rej_q     <= 1'b0;
			end else begin
				phase_q   <= phase_d;
				cnt_q     <= cnt_d;
				any_reg_q <= any_reg_d;
				seen_q    <= seen_d;
				disp_q    <= disp_d;
				start_q   <= start_d;
				rej_q     <= rej_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take && instr.last_byte) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && instr.last_byte) begin
			dec_s1.hit   <= !rej_d && (phase_d == PH_TAIL);
			dec_s1.start <= start_d;
			dec_s1.len   <= cnt_d;
			dec_s1.disp  <= disp_d;
		end
	end

endmodule

>>> design/rwtd_target.sv
// rwtd_target: target address adder stage and the result register with the watch compare
// depends on rwtd_pkg and rwtd_out_if

module rwtd_target (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_s1,
	input  rwtd_pkg::decode_t         dec_s1,
	input  logic [rwtd_pkg::ADDR_W-1:0] watched_address,
	output logic                      adv_s1,
	rwtd_out_if.source                report
);
	import rwtd_pkg::*;

	logic              valid_s2;
	logic              hit_s2;
	logic [ADDR_W-1:0] target_s2;
	logic [ADDR_W-1:0] sum;
	logic              adv_out;

	logic              valid_q;
	logic              is_rip_write_q;
	logic [ADDR_W-1:0] write_target_q;
	logic              hits_watched_q;

	assign adv_out = !valid_q || report.ready;
	assign adv_s1  = !valid_s2 || adv_out;

	// start + length + sign-extended disp32
	assign sum = dec_s1.start + ADDR_W'(dec_s1.len) +
		{{(ADDR_W-DISP_W){dec_s1.disp[DISP_W-1]}}, dec_s1.disp};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			hit_s2    <= dec_s1.hit;
			target_s2 <= dec_s1.hit ? sum : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv_out) begin
			valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			is_rip_write_q <= hit_s2;
			write_target_q <= target_s2;
			hits_watched_q <= hit_s2 && (target_s2 == watched_address);
		end
	end

	assign report.valid        = valid_q;
	assign report.is_rip_write = is_rip_write_q;
	assign report.write_target = write_target_q;
	assign report.hits_watched = hits_watched_q;

endmodule

>>> design/rip_relative_write_target_decoder.sv
// rip_relative_write_target_decoder: top level, watch register and the parse/target pipeline
// depends on rwtd_pkg, rwtd_if, rwtd_parser and rwtd_target
//
//   channel  direction  item                       accepted when
//   instr    sink       one instruction byte       instr.valid && instr.ready
//   report   source     one decode per instruction report.valid && report.ready
//   wr_*     sink       watched address write      wr_en
//
// one byte per cycle while instr.ready is high; a report moves through the stages below
// stages: parse state and decode register, target adder register, result register
// a stalled report fills the two stages behind it before instr.ready drops
// arst_n clears the parse state, all stage valids and the watched address

module rip_relative_write_target_decoder #(
	parameter int MAX_INSTR_BYTES = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	rwtd_in_if.sink     instr,
	rwtd_out_if.source  report,
	input  logic        wr_en,
	input  logic [63:0] wr_data
);
	import rwtd_pkg::*;

	logic [ADDR_W-1:0] watched_address_q;
	logic              valid_s1;
	decode_t           dec_s1;
	logic              adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watched_address_q <= '0;
		end else if (wr_en) begin
			watched_address_q <= wr_data;
		end
	end

	rwtd_parser #(
		.MAX_INSTR_BYTES (MAX_INSTR_BYTES)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.instr    (instr),
		.adv_s1   (adv_s1),
		.valid_s1 (valid_s1),
		.dec_s1   (dec_s1)
	);

	rwtd_target u_target (
		.clk             (clk),
		.arst_n          (arst_n),
		.valid_s1        (valid_s1),
		.dec_s1          (dec_s1),
		.watched_address (watched_address_q),
		.adv_s1          (adv_s1),
		.report          (report)
	);

endmodule

>>> design/rwtd_checker.sv
// rwtd_checker: port-level assertions on the decoder's report channel
// no dependencies; bound to rip_relative_write_target_decoder

module rwtd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        is_rip_write,
	input logic [63:0] write_target,
	input logic        hits_watched
);

	// a non-write report carries a zero target
	a_no_write_zero_target: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !is_rip_write |-> write_target == 64'h0)
		else $error("non-write report with nonzero target");

	// a watch hit only comes with a decoded write
	a_hit_needs_write: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && hits_watched |-> is_rip_write)
		else $error("watch hit without rip-relative write");

	// stalled report holds
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(is_rip_write) &&
			$stable(write_target) && $stable(hits_watched))
		else $error("stalled report changed");

endmodule

bind rip_relative_write_target_decoder rwtd_checker u_rwtd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (report.valid),
	.res_ready    (report.ready),
	.is_rip_write (report.is_rip_write),
	.write_target (report.write_target),
	.hits_watched (report.hits_watched)
);

>>> tb/sv/tb_rip_relative_write_target_decoder.sv
`timescale 1ns / 1ps
// tb_rip_relative_write_target_decoder: byte-stream stimulus, own decode predictor and report checks
// depends on rwtd_pkg, rwtd_if and rip_relative_write_target_decoder

module tb_rip_relative_write_target_decoder;
	import rwtd_pkg::*;

	localparam int MAX_BYTES   = 15;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE      = 8;

	typedef struct packed {
		logic        is_rip_write;
		logic [63:0] write_target;
		logic        hits_watched;
	} report_t;

	typedef struct packed {
		logic [7:0]  code;
		logic [63:0] addr;
		logic        last;
	} code_item_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [63:0] wr_data;

	rwtd_in_if  instr_ch ();
	rwtd_out_if report_ch ();

	rip_relative_write_target_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.instr   (instr_ch),
		.report  (report_ch),
		.wr_en   (wr_en),
		.wr_data (wr_data)
	);

	code_item_t  byte_q[$];
	report_t     expected_reports[$];
	logic [7:0]  instr_bytes[$];
	int          src_idle_pct;
	int          sink_idle_pct;
	int          mismatches;
	int          cycles;
	int          bytes_made;

	// decoder state as seen by the predictor
	phase_t      ph;
	logic [3:0]  taken;
	logic        reg_free;
	logic [2:0]  disp_cnt;
	logic [31:0] disp_acc;
	logic [63:0] base_addr;
	logic        dead;
	logic [63:0] watched;

	function automatic logic is_legacy_pfx(logic [7:0] b);
		return b == PFX_LOCK || b == PFX_REPNE || b == PFX_REP || b == PFX_CS ||
			b == PFX_SS || b == PFX_DS || b == PFX_ES || b == PFX_FS ||
			b == PFX_GS || b == PFX_OPSIZE || b == PFX_ADSIZE;
	endfunction

	function automatic void take_opcode(logic [7:0] b);
		if (b == OP_ESCAPE) begin
			ph = PH_ESCAPE;
		end else if (b == OP_MOV_RM_R || b == OP_ADD_RM_R) begin
			reg_free = 1'b1;
			ph = PH_MODRM;
		end else if (b == OP_MOV_RM_IMM || b == OP_GRP1_IMM32 || b == OP_GRP1_IMM8 ||
				b == OP_GRP5) begin
			reg_free = 1'b0;
			ph = PH_MODRM;
		end else begin
			dead = 1'b1;
		end
	endfunction

	function automatic void clear_decode();
		ph = PH_PREFIX;
		taken = '0;
		reg_free = 1'b0;
		disp_cnt = '0;
		disp_acc = '0;
		base_addr = '0;
		dead = 1'b0;
	endfunction

	// advances the decode by one byte; returns 1 with the report on a marked byte
	function automatic logic rip_decode_step(logic [7:0] b, logic [63:0] a, logic last,
			output report_t r);
		logic hit;
		logic [63:0] tgt;
		r = '0;
		if (taken == 0)
			base_addr = a;
		if (taken >= MAX_BYTES)
			dead = 1'b1;
		else
			taken = taken + 4'd1;
		if (!dead) begin
			case (ph)
				PH_PREFIX: begin
					if (!is_legacy_pfx(b)) begin
						if ((b & REX_MASK) == REX_BASE)
							ph = PH_OPCODE;
						else
							take_opcode(b);
					end
				end
				PH_OPCODE: begin
					take_opcode(b);
				end
				PH_ESCAPE: begin
					if (b == OP_XADD) begin
						reg_free = 1'b1;
						ph = PH_MODRM;
					end else begin
						dead = 1'b1;
					end
				end
				PH_MODRM: begin
					if ((b & MODRM_MODRM_MASK) == MODRM_RIP_DISP32 &&
							(reg_free || (b & MODRM_REG_MASK) == 8'h00)) begin
						disp_cnt = '0;
						disp_acc = '0;
						ph = PH_DISP;
					end else begin
						dead = 1'b1;
					end
				end
				PH_DISP: begin
					disp_acc = disp_acc | (32'(b) << (8 * disp_cnt[1:0]));
					disp_cnt = disp_cnt + 3'd1;
					if (disp_cnt >= 3'd4)
						ph = PH_TAIL;
				end
				default: ;
			endcase
		end
		if (!last)
			return 1'b0;
		hit = !dead && ph == PH_TAIL;
		tgt = hit ? base_addr + 64'(taken) + {{32{disp_acc[31]}}, disp_acc} : 64'd0;
		r.is_rip_write = hit;
		r.write_target = tgt;
		r.hits_watched = hit && tgt == watched;
		clear_decode();
		return 1'b1;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [7:0] pick_prefix();
		case ($urandom_range(10))
			0: return PFX_LOCK;
			1: return PFX_REPNE;
			2: return PFX_REP;
			3: return PFX_CS;
			4: return PFX_SS;
			5: return PFX_DS;
			6: return PFX_ES;
			7: return PFX_FS;
			8: return PFX_GS;
			9: return PFX_OPSIZE;
			default: return PFX_ADSIZE;
		endcase
	endfunction

	// appends one byte to the instruction being built
	task automatic put_byte(input logic [7:0] v);
		instr_bytes.insert(instr_bytes.size(), v);
	endtask

	// moves the bytes built so far into the send queue as one instruction
	task automatic emit_instr(input logic [63:0] start);
		code_item_t it;
		for (int i = 0; i < instr_bytes.size(); i++) begin
			it.code = instr_bytes[i];
			it.addr = (i == 0) ? start : rand64();
			it.last = (i == instr_bytes.size() - 1);
			byte_q.insert(byte_q.size(), it);
		end
		bytes_made += instr_bytes.size();
		instr_bytes.delete();
	endtask

	// write with random content, well-formed unless spoil damages it; aim puts the target on the watched address
	task automatic add_write(input bit aim, input bit spoil);
		int n_pfx;
		int opk;
		int mi;
		int dmg;
		int n;
		logic [7:0] junk;
		logic [31:0] d;
		logic [63:0] start;
		dmg = spoil ? $urandom_range(3) : 4;
		n_pfx = ($urandom_range(9) == 0) ? $urandom_range(12, 5) : $urandom_range(3);
		repeat (n_pfx) put_byte(pick_prefix());
		if (dmg == 3 || $urandom_range(1)) begin
			put_byte(REX_BASE | 8'($urandom_range(15)));
			// a prefix after the rex byte kills the match
			if (dmg == 3)
				put_byte(pick_prefix());
		end
		opk = $urandom_range(6);
		case (opk)
			0: begin
				put_byte(OP_ESCAPE);
				put_byte(OP_XADD);
			end
			1: put_byte(OP_MOV_RM_R);
			2: put_byte(OP_ADD_RM_R);
			3: put_byte(OP_MOV_RM_IMM);
			4: put_byte(OP_GRP1_IMM32);
			5: put_byte(OP_GRP1_IMM8);
			default: put_byte(OP_GRP5);
		endcase
		mi = instr_bytes.size();
		put_byte(MODRM_RIP_DISP32 | ((opk <= 2) ? 8'($urandom_range(7)) << 3 : 8'h00));
		case ($urandom_range(7))
			0: d = 32'h0000_0000;
			1: d = 32'h7FFF_FFFF;
			2: d = 32'h8000_0000;
			3: d = 32'hFFFF_FFFF;
			default: d = $urandom;
		endcase
		for (int i = 0; i < 4; i++)
			put_byte(d[8*i +: 8]);
		repeat ($urandom_range(4)) put_byte(8'($urandom));
		case (dmg)
			0: instr_bytes[$urandom_range(instr_bytes.size() - 1)] = 8'($urandom);
			1: begin
				n = $urandom_range(1, instr_bytes.size() - 1);
				while (instr_bytes.size() > n)
					junk = instr_bytes.pop_back();
			end
			2: instr_bytes[mi] = instr_bytes[mi] ^ 8'(1 << $urandom_range(7));
			default: ;
		endcase
		start = aim ? watched - 64'(instr_bytes.size()) - {{32{d[31]}}, d} : rand64();
		emit_instr(start);
	endtask

	task automatic add_noise();
		repeat ($urandom_range(1, 20))
			put_byte(($urandom_range(2) == 0) ? pick_prefix() : 8'($urandom));
		emit_instr(rand64());
	endtask

	// sender holds off until every report is back and the pipeline has settled
	task automatic drain();
		while (byte_q.size() != 0 || instr_ch.valid || expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_watched(input logic [63:0] v);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_data <= v;
		watched = v;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin : byte_driver
		code_item_t nxt;
		report_t r;
		if (!arst_n) begin
			instr_ch.valid <= 1'b0;
		end else begin
			if (instr_ch.valid && instr_ch.ready) begin
				if (rip_decode_step(instr_ch.code_byte, instr_ch.instruction_address,
						instr_ch.last_byte, r))
					expected_reports.insert(expected_reports.size(), r);
			end
			if (!instr_ch.valid || instr_ch.ready) begin
				if (byte_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					nxt = byte_q.pop_front();
					instr_ch.valid <= 1'b1;
					instr_ch.code_byte <= nxt.code;
					instr_ch.instruction_address <= nxt.addr;
					instr_ch.last_byte <= nxt.last;
				end else begin
					instr_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : report_monitor
		report_t want;
		if (arst_n && report_ch.valid && report_ch.ready) begin
			if (expected_reports.size() == 0) begin
				$error("report with none expected: is_rip_write %0d write_target %h",
					report_ch.is_rip_write, report_ch.write_target);
				mismatches++;
			end else begin
				want = expected_reports.pop_front();
				if (report_ch.is_rip_write !== want.is_rip_write) begin
					$error("is_rip_write: expected %0d, got %0d", want.is_rip_write,
						report_ch.is_rip_write);
					mismatches++;
				end
				if (report_ch.write_target !== want.write_target) begin
					$error("write_target: expected %h, got %h", want.write_target,
						report_ch.write_target);
					mismatches++;
				end
				if (report_ch.hits_watched !== want.hits_watched) begin
					$error("hits_watched: expected %0d, got %0d", want.hits_watched,
						report_ch.hits_watched);
					mismatches++;
				end
			end
		end
		report_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	initial begin
		logic [63:0] settings [6];
		int sel;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_data = '0;
		instr_ch.valid = 1'b0;
		instr_ch.code_byte = '0;
		instr_ch.instruction_address = '0;
		instr_ch.last_byte = 1'b0;
		report_ch.ready = 1'b0;
		mismatches = 0;
		cycles = 0;
		bytes_made = 0;
		src_idle_pct = 36;
		sink_idle_pct = 36;
		watched = '0;
		clear_decode();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: watched address still at its reset value of zero
		instr_bytes = '{8'h90};
		emit_instr(64'h0);
		// rex, any reg, most negative disp; target lands exactly on zero
		instr_bytes = '{8'h48, OP_MOV_RM_R, 8'h05, 8'h00, 8'h00, 8'h00, 8'h80};
		emit_instr(64'h0000_0000_7FFF_FFF9);
		// escape form with reg 7 and largest disp, start at the top of the address space
		instr_bytes = '{OP_ESCAPE, OP_XADD, 8'h3D, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
		emit_instr(64'hFFFF_FFFF_FFFF_FFFF);
		// nonzero reg where reg must be zero
		instr_bytes = '{OP_MOV_RM_IMM, 8'h0D};
		emit_instr(rand64());
		// escape not followed by xadd
		instr_bytes = '{OP_ESCAPE, 8'h90};
		emit_instr(rand64());
		// second rex byte
		instr_bytes = '{8'h48, 8'h48};
		emit_instr(rand64());
		// ends inside the displacement
		instr_bytes = '{OP_MOV_RM_R, 8'h05, 8'h01, 8'h02};
		emit_instr(rand64());
		drain();

		settings[0] = 64'hFFFF_FFFF_FFFF_FFFF;
		settings[1] = 64'h0;
		settings[2] = rand64();
		settings[3] = 64'h8000_0000_0000_0000;
		settings[4] = rand64();
		settings[5] = rand64();
		for (int p = 0; p < 6; p++) begin
			write_watched(settings[p]);
			// one phase runs with no idling on either side
			src_idle_pct = (p == 2) ? 0 : 36;
			sink_idle_pct = (p == 2) ? 0 : 36;
			bytes_made = 0;
			while (bytes_made < 170) begin
				sel = $urandom_range(99);
				if (sel < 65)
					add_write($urandom_range(9) < 3, 1'b0);
				else if (sel < 85)
					add_write(1'b0, 1'b1);
				else
					add_noise();
			end
			drain();
		end

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> filelist.f
design/rwtd_pkg.sv
design/rwtd_if.sv
design/rwtd_parser.sv
design/rwtd_target.sv
design/rip_relative_write_target_decoder.sv
design/rwtd_checker.sv
tb/sv/tb_rip_relative_write_target_decoder.sv
